[rtl/core/signed_feature_hasher_macros.svh]
// Assertion macros shared by the signed feature hasher RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SIGNED_FEATURE_HASHER_MACROS_SVH
`define SIGNED_FEATURE_HASHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sfh_pkg.sv]
// Package for the signed feature hasher: constants, widths and shared types.
// Used by sfh_mul_unit and signed_feature_hasher; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfh_pkg;

  // Hash word and field widths.
  localparam int HASH_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int BUCKET_W    = 16;
  localparam int DIV_CNT_W   = $clog2(HASH_W);

  // Digit width of the shared multiplier (8, 16 or 32).
  localparam int MUL_DIGIT_W = 16;

  // Mixing constants.
  localparam logic [HASH_W-1:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
  localparam int                HASH_SHIFT = 47;
  localparam logic [HASH_W-1:0] SIGN_XOR  = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_W-1:0] SIGN_MUL  = 64'hbf58476d1ce4e5b9;
  localparam int                SIGN_SHIFT = 31;

  // Reset value of the bucket count register.
  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 16'd76;

  // Command to the shared multiplier.
  typedef struct packed {
    logic start;       // load operand and begin a product
    logic sign_round;  // use the sign-round constant instead of the hash one
  } mul_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/sfh_mul_unit.sv]
// Shared digit-serial multiplier: 64-bit operand times a 64-bit constant, mod 2^64.
// Depends on sfh_pkg for widths, constants and the mul_ctrl_t command struct.
`timescale 1ns / 1ps
`default_nettype none

module sfh_mul_unit #(
  parameter int DigitW = sfh_pkg::MUL_DIGIT_W
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  sfh_pkg::mul_ctrl_t     ctrl_i,
  input  wire  [sfh_pkg::HASH_W-1:0]   operand_i,
  output logic [sfh_pkg::HASH_W-1:0]   result_o,
  output logic                         done_o
);

  localparam int Steps = sfh_pkg::HASH_W / DigitW;
  localparam int CntW  = $clog2(Steps);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [sfh_pkg::HASH_W-1:0]  opnd_q;
  logic [sfh_pkg::HASH_W-1:0]  const_q;
  logic [sfh_pkg::HASH_W-1:0]  acc_q;
  logic [sfh_pkg::HASH_W-1:0]  prod_w;
  logic                        last_step_w;

  // One digit of the operand times the constant, already aligned by shifting
  // the constant left one digit per step. Only the low 64 bits are kept.
  assign prod_w = {{(sfh_pkg::HASH_W - DigitW){1'b0}}, opnd_q[DigitW-1:0]} * const_q;

  assign last_step_w = (cnt_q == CntW'(Steps - 1));

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last_step_w) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand, constant and accumulator.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      opnd_q  <= operand_i;
      const_q <= ctrl_i.sign_round ? sfh_pkg::SIGN_MUL : sfh_pkg::HASH_MUL;
      acc_q   <= '0;
    end else if (busy_q) begin
      acc_q   <= acc_q + prod_w;
      opnd_q  <= opnd_q >> DigitW;
      const_q <= const_q << DigitW;
    end
  end

  assign result_o = acc_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

[rtl/core/signed_feature_hasher.sv]
// Signed feature hasher top level: byte mixing, sign round and bucket modulo.
// Depends on sfh_pkg, sfh_mul_unit and signed_feature_hasher_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte of a feature
//   string per item, with last_byte_i set on the final byte. Output channel
//   (out_valid_o / out_stall_i) carries one item per feature: bucket_index_o
//   and sign_positive_o. The bucket count is written through cfg_we_i and
//   cfg_wdata_i; the user must write it only while the block is idle, as the
//   block itself does not enforce this. A count of zero gives bucket 0.
//   The block works on one byte at a time and stalls its input while busy.
//   A byte without the mark takes 4 steps of the shared 16x64 multiplier
//   plus load and fold before the next byte can be taken. A marked byte adds
//   a second 4-step product for the sign and a restoring division of 64
//   one-bit steps for the bucket before its item is ready.
//   The result sits in an output register; while the receiver stalls it, the
//   block still takes and mixes further bytes and waits only when the next
//   result is ready. Reset clears the running hash, sets the bucket count
//   to 76 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_feature_hasher_macros.svh"

module signed_feature_hasher #(
  parameter int MulDigitW = sfh_pkg::MUL_DIGIT_W
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration
  input  wire                              cfg_we_i,
  input  wire  [sfh_pkg::BUCKET_W-1:0]     cfg_wdata_i,
  // Input items
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [sfh_pkg::BYTE_W-1:0]       byte_value_i,
  input  wire                              last_byte_i,
  // Output items
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [sfh_pkg::BUCKET_W-1:0]     bucket_index_o,
  output logic                             sign_positive_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_SIGN,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                          state_q;
  logic [sfh_pkg::HASH_W-1:0]      hash_q;
  logic                            last_q;
  logic [sfh_pkg::HASH_W-1:0]      div_q;
  logic [sfh_pkg::BUCKET_W-1:0]    rem_q;
  logic [sfh_pkg::DIV_CNT_W-1:0]   div_cnt_q;
  logic [sfh_pkg::BUCKET_W-1:0]    cfg_bucket_q;
  logic [sfh_pkg::BUCKET_W-1:0]    bucket_q;
  logic                            sign_q;
  logic                            out_valid_q;
  logic [sfh_pkg::BUCKET_W-1:0]    out_bucket_q;
  logic                            out_sign_q;

  sfh_pkg::mul_ctrl_t              mul_ctrl_w;
  logic [sfh_pkg::HASH_W-1:0]      mul_opnd_w;
  logic [sfh_pkg::HASH_W-1:0]      mul_res_w;
  logic                            mul_done_w;

  logic                            in_accept_w;
  logic [sfh_pkg::HASH_W-1:0]      byte_ext_w;
  logic [sfh_pkg::HASH_W-1:0]      mixed_w;
  logic [sfh_pkg::BUCKET_W:0]      shifted_w;
  logic [sfh_pkg::BUCKET_W-1:0]    diff_w;
  logic [sfh_pkg::BUCKET_W-1:0]    rem_d;
  logic                            out_free_w;
  logic                            out_load_w;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept_w = in_valid_i && !in_stall_o;

  // Sign-extend the byte, as a signed char would be.
  assign byte_ext_w = {{(sfh_pkg::HASH_W - sfh_pkg::BYTE_W){byte_value_i[sfh_pkg::BYTE_W-1]}},
                       byte_value_i};

  // Fold step after the per-byte product.
  assign mixed_w = mul_res_w ^ (mul_res_w >> sfh_pkg::HASH_SHIFT);

  // Multiplier commands: a byte product on acceptance, a sign-round product
  // right after the last byte's fold.
  always_comb begin
    mul_ctrl_w.start      = in_accept_w || (state_q == ST_MIX && mul_done_w && last_q);
    mul_ctrl_w.sign_round = (state_q == ST_MIX);
    mul_opnd_w            = (state_q == ST_MIX) ? (mixed_w ^ sfh_pkg::SIGN_XOR)
                                                : (hash_q ^ byte_ext_w);
  end

  sfh_mul_unit #(
    .DigitW (MulDigitW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl_w),
    .operand_i (mul_opnd_w),
    .result_o  (mul_res_w),
    .done_o    (mul_done_w)
  );

  // One restoring division step: shift in the next hash bit, subtract if it fits.
  // The difference is below the bucket count whenever it is taken, so 16 bits hold it.
  always_comb begin
    shifted_w = {rem_q, div_q[sfh_pkg::HASH_W-1]};
    diff_w    = shifted_w[sfh_pkg::BUCKET_W-1:0] - bucket_q;
    rem_d     = (shifted_w >= {1'b0, bucket_q}) ? diff_w
                                                 : shifted_w[sfh_pkg::BUCKET_W-1:0];
  end

  assign out_free_w = !out_valid_q || !out_stall_i;
  assign out_load_w = (state_q == ST_HOLD) && out_free_w;

  // Sequencer, running hash, divider and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hash_q       <= '0;
      last_q       <= 1'b0;
      div_q        <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      cfg_bucket_q <= sfh_pkg::BUCKET_RESET;
      bucket_q     <= '0;
      sign_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_bucket_q <= '0;
      out_sign_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_bucket_q <= cfg_wdata_i;
      end

      // A new item enters the output register, or the receiver took the pending one.
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept_w) begin
            last_q  <= last_byte_i;
            state_q <= ST_MIX;
          end
        end
        ST_MIX: begin
          if (mul_done_w) begin
            if (last_q) begin
              hash_q  <= '0;
              div_q   <= mixed_w;
              state_q <= ST_SIGN;
            end else begin
              hash_q  <= mixed_w;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SIGN: begin
          if (mul_done_w) begin
            sign_q    <= mul_res_w[0] ^ mul_res_w[sfh_pkg::SIGN_SHIFT];
            bucket_q  <= cfg_bucket_q;
            rem_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q     <= rem_d;
          div_q     <= div_q << 1;
          div_cnt_q <= div_cnt_q + sfh_pkg::DIV_CNT_W'(1);
          if (div_cnt_q == sfh_pkg::DIV_CNT_W'(sfh_pkg::HASH_W - 1)) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load_w) begin
            out_bucket_q <= (bucket_q == '0) ? '0 : rem_q;
            out_sign_q   <= sign_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bucket_index_o  = out_bucket_q;
  assign sign_positive_o = out_sign_q;

  // A new result appears only out of the hold state.
  `SFH_ASSERT_IMPL(a_out_from_hold, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_HOLD), "output item rose outside the hold state")
  // The multiplier finishes only while the sequencer waits for it.
  `SFH_ASSERT_IMPL(a_mul_done_expected, clk_i, rst_ni, mul_done_w, (state_q == ST_MIX) || (state_q == ST_SIGN), "multiplier finished while not awaited")
  // The running hash is already cleared while the bucket is computed.
  `SFH_ASSERT_IMPL(a_hash_cleared, clk_i, rst_ni, (state_q == ST_DIV) || (state_q == ST_HOLD), hash_q == '0, "running hash not cleared after last byte")
  // The final remainder is below a nonzero bucket count.
  `SFH_ASSERT_IMPL(a_rem_in_range, clk_i, rst_ni, (state_q == ST_HOLD) && (bucket_q != '0), rem_q < bucket_q, "bucket remainder out of range")

endmodule

`default_nettype wire
